// ----- hdl/ising_metropolis_update_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ISING_METROPOLIS_UPDATE_ASSERT_SVH
`define ISING_METROPOLIS_UPDATE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define ISM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ISM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/ism_pkg.sv -----
package ism_pkg;

   localparam int LATTICE_SIZE = 64;
   localparam int SITE_COUNT   = LATTICE_SIZE * LATTICE_SIZE;
   localparam int ROW_W        = $clog2(LATTICE_SIZE);

   localparam int KIND_W       = 2;
   localparam int COORD_W      = 6;
   localparam int COORD_EXT_W  = 9;
   localparam int FRAC_W       = 32;
   localparam int RATIO_W      = 33;
   localparam int DELTA_W      = 5;
   localparam int ENERGY_OUT_W = 15;
   localparam int MAG_OUT_W    = 14;
   localparam int ENERGY_W     = $clog2(2 * SITE_COUNT) + 2;
   localparam int MAG_W        = $clog2(SITE_COUNT) + 2;
   localparam int CSR_IDX_W    = 2;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COORD_EXT_W-1:0] COORD_LIMIT = COORD_EXT_W'(LATTICE_SIZE);
   localparam logic [ROW_W-1:0]       LAST_IDX    = ROW_W'(LATTICE_SIZE - 1);

   localparam logic signed [ENERGY_W-1:0] ENERGY_ALL_UP = ENERGY_W'(-2 * SITE_COUNT);
   localparam logic signed [MAG_W-1:0]    MAG_ALL_UP    = MAG_W'(SITE_COUNT);
   localparam logic [RATIO_W-1:0]         RATIO_ONE     = 33'h1_0000_0000;

   localparam logic [KIND_W-1:0] KIND_TRIAL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_MINUS8 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_MINUS4 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_PLUS4  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_PLUS8  = 2'd3;

   localparam logic signed [DELTA_W-1:0] DE_MINUS8 = -5'sd8;
   localparam logic signed [DELTA_W-1:0] DE_MINUS4 = -5'sd4;
   localparam logic signed [DELTA_W-1:0] DE_PLUS4  = 5'sd4;
   localparam logic signed [DELTA_W-1:0] DE_PLUS8  = 5'sd8;

   typedef enum logic [2:0] {
      OP_TRIAL,
      OP_WRITE,
      OP_CLEAR,
      OP_RANGE_ERR,
      OP_IGNORE
   } op_code_type;

   typedef struct packed {
      op_code_type       code;
      logic [ROW_W-1:0]  row;
      logic [ROW_W-1:0]  col;
      logic [FRAC_W-1:0] rand_frac;
      logic              spin_up;
   } op_type;

   typedef struct packed {
      logic [RATIO_W-1:0] minus8;
      logic [RATIO_W-1:0] minus4;
      logic [RATIO_W-1:0] plus4;
      logic [RATIO_W-1:0] plus8;
   } ratio_set_type;

   typedef struct packed {
      logic                           accepted;
      logic signed [DELTA_W-1:0]      delta_energy;
      logic signed [ENERGY_OUT_W-1:0] energy;
      logic signed [MAG_OUT_W-1:0]    magnetization;
      logic                           status;
   } result_type;

endpackage

// ----- hdl/ism_front.sv -----
module ism_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [ism_pkg::KIND_W-1:0]   req_kind,
   input  logic [ism_pkg::COORD_W-1:0]  req_site_row,
   input  logic [ism_pkg::COORD_W-1:0]  req_site_col,
   input  logic [ism_pkg::FRAC_W-1:0]   req_rand_frac,
   input  logic                         req_spin_up,
   output ism_pkg::op_type              op,
   output logic                         op_valid,
   input  logic                         op_pop
);
   import ism_pkg::*;

   op_type                 classified;
   logic                   in_range;
   logic                   push;
   logic                   pop;
   op_type                 op_q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;

   always_comb begin
      in_range = (COORD_EXT_W'(req_site_row) < COORD_LIMIT) &&
                 (COORD_EXT_W'(req_site_col) < COORD_LIMIT);
      classified.row       = ROW_W'(req_site_row);
      classified.col       = ROW_W'(req_site_col);
      classified.rand_frac = req_rand_frac;
      classified.spin_up   = req_spin_up;
      case (req_kind)
         KIND_TRIAL: classified.code = in_range ? OP_TRIAL : OP_RANGE_ERR;
         KIND_WRITE: classified.code = in_range ? OP_WRITE : OP_RANGE_ERR;
         KIND_CLEAR: classified.code = OP_CLEAR;
         default:    classified.code = OP_IGNORE;
      endcase
   end

   assign req_full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign op_valid = (count_ff != '0);
   assign op       = op_q_ff[rd_ptr_ff];
   assign push     = req_push && !req_full;
   assign pop      = op_pop && op_valid;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            op_q_ff[wr_ptr_ff] <= classified;
            wr_ptr_ff          <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/ism_back.sv -----
module ism_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ism_pkg::op_type        op,
   input  logic                   op_valid,
   output logic                   op_pop,
   input  ism_pkg::ratio_set_type ratios,
   input  logic                   res_full,
   output logic                   res_push,
   output ism_pkg::result_type    res
);
   import ism_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CENTER,
      ST_EVAL,
      ST_DONE
   } state_type;

   state_type                   state_ff;
   op_type                      op_ff;
   logic [LATTICE_SIZE-1:0]     spin_mem_ff [LATTICE_SIZE];
   logic [LATTICE_SIZE-1:0]     row_valid_ff;
   logic [LATTICE_SIZE-1:0]     rd_a_ff;
   logic [LATTICE_SIZE-1:0]     rd_b_ff;
   logic                        rd_a_vld_ff;
   logic                        rd_b_vld_ff;
   logic [LATTICE_SIZE-1:0]     up_row_ff;
   logic [LATTICE_SIZE-1:0]     dn_row_ff;
   logic [LATTICE_SIZE-1:0]     new_row_ff;
   logic                        flip_ff;
   logic                        clear_ff;
   logic signed [ENERGY_W-1:0]  energy_ff;
   logic signed [MAG_W-1:0]     mag_ff;
   logic signed [ENERGY_W-1:0]  energy_nx_ff;
   logic signed [MAG_W-1:0]     mag_nx_ff;
   result_type                  res_ff;

   logic                        rd_a_en;
   logic                        rd_b_en;
   logic [ROW_W-1:0]            rd_a_addr;
   logic [ROW_W-1:0]            rd_b_addr;
   logic                        mem_we;

   logic [LATTICE_SIZE-1:0]     center_row;
   logic [LATTICE_SIZE-1:0]     eff_a;
   logic [LATTICE_SIZE-1:0]     eff_b;
   logic [LATTICE_SIZE-1:0]     new_row_in;
   logic [ROW_W-1:0]            col_left;
   logic [ROW_W-1:0]            col_right;
   logic                        spin_self;
   logic [2:0]                  ups;
   logic signed [5:0]           four_k;
   logic signed [5:0]           de_wide;
   logic signed [DELTA_W-1:0]   de;
   logic [RATIO_W-1:0]          thr;
   logic                        flip_in;
   logic                        clear_in;
   logic                        status_in;
   logic signed [ENERGY_W-1:0]  energy_in;
   logic signed [MAG_W-1:0]     mag_in;
   result_type                  res_in;

   function automatic logic [ROW_W-1:0] wrap_next(input logic [ROW_W-1:0] idx);
      wrap_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [ROW_W-1:0] wrap_prev(input logic [ROW_W-1:0] idx);
      wrap_prev = (idx == '0) ? LAST_IDX : idx - 1'b1;
   endfunction

   // A row whose valid bit is clear has not been written since the last
   // set-all-up and reads as all spins up.
   assign eff_a      = rd_a_vld_ff ? rd_a_ff : '1;
   assign eff_b      = rd_b_vld_ff ? rd_b_ff : '1;
   assign center_row = eff_a;

   always_comb begin
      op_pop    = 1'b0;
      rd_a_en   = 1'b0;
      rd_b_en   = 1'b0;
      rd_a_addr = op_ff.row;
      rd_b_addr = op_ff.row;
      case (state_ff)
         ST_IDLE: begin
            op_pop    = op_valid;
            rd_a_en   = op_valid;
            rd_b_en   = op_valid;
            rd_a_addr = wrap_prev(op.row);
            rd_b_addr = wrap_next(op.row);
         end
         ST_CENTER: begin
            rd_a_en   = 1'b1;
            rd_a_addr = op_ff.row;
         end
         default: begin
            rd_a_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      col_left   = wrap_prev(op_ff.col);
      col_right  = wrap_next(op_ff.col);
      spin_self  = center_row[op_ff.col];
      ups        = 3'(up_row_ff[op_ff.col]) + 3'(dn_row_ff[op_ff.col]) +
                   3'(center_row[col_left]) + 3'(center_row[col_right]);
      four_k     = signed'({1'b0, ups, 2'b00});
      de_wide    = spin_self ? (four_k - 6'sd8) : (6'sd8 - four_k);
      de         = DELTA_W'(de_wide);
      new_row_in = center_row ^ (LATTICE_SIZE'(1) << op_ff.col);

      case (de)
         DE_MINUS8: thr = ratios.minus8;
         DE_MINUS4: thr = ratios.minus4;
         DE_PLUS4:  thr = ratios.plus4;
         DE_PLUS8:  thr = ratios.plus8;
         default:   thr = RATIO_ONE;
      endcase

      flip_in   = 1'b0;
      clear_in  = 1'b0;
      status_in = 1'b0;
      case (op_ff.code)
         OP_TRIAL:     flip_in   = ({1'b0, op_ff.rand_frac} <= thr);
         OP_WRITE:     flip_in   = (spin_self != op_ff.spin_up);
         OP_CLEAR:     clear_in  = 1'b1;
         OP_RANGE_ERR: status_in = 1'b1;
         default:      flip_in   = 1'b0;
      endcase

      if (clear_in) begin
         energy_in = ENERGY_ALL_UP;
         mag_in    = MAG_ALL_UP;
      end else if (flip_in) begin
         energy_in = energy_ff + ENERGY_W'(de);
         mag_in    = spin_self ? (mag_ff - MAG_W'(2)) : (mag_ff + MAG_W'(2));
      end else begin
         energy_in = energy_ff;
         mag_in    = mag_ff;
      end

      res_in.accepted      = flip_in;
      res_in.delta_energy  = flip_in ? de : '0;
      res_in.energy        = ENERGY_OUT_W'(energy_in);
      res_in.magnetization = MAG_OUT_W'(mag_in);
      res_in.status        = status_in;
   end

   assign res_push = (state_ff == ST_DONE) && !res_full;
   assign res      = res_ff;
   assign mem_we   = res_push && flip_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         spin_mem_ff[op_ff.row] <= new_row_ff;
      end
      if (rd_a_en) begin
         rd_a_ff <= spin_mem_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= spin_mem_ff[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_valid_ff <= '0;
         energy_ff    <= ENERGY_ALL_UP;
         mag_ff       <= MAG_ALL_UP;
      end else begin
         if (rd_a_en) begin
            rd_a_vld_ff <= row_valid_ff[rd_a_addr];
         end
         if (rd_b_en) begin
            rd_b_vld_ff <= row_valid_ff[rd_b_addr];
         end
         case (state_ff)
            ST_IDLE: begin
               if (op_valid) begin
                  op_ff    <= op;
                  state_ff <= ST_CENTER;
               end
            end
            ST_CENTER: begin
               up_row_ff <= eff_a;
               dn_row_ff <= eff_b;
               state_ff  <= ST_EVAL;
            end
            ST_EVAL: begin
               res_ff       <= res_in;
               new_row_ff   <= new_row_in;
               flip_ff      <= flip_in;
               clear_ff     <= clear_in;
               energy_nx_ff <= energy_in;
               mag_nx_ff    <= mag_in;
               state_ff     <= ST_DONE;
            end
            ST_DONE: begin
               if (!res_full) begin
                  energy_ff <= energy_nx_ff;
                  mag_ff    <= mag_nx_ff;
                  if (clear_ff) begin
                     row_valid_ff <= '0;
                  end else if (flip_ff) begin
                     row_valid_ff[op_ff.row] <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- hdl/ism_rspq.sv -----
module ism_rspq (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_push,
   input  ism_pkg::result_type res,
   output logic                res_full,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output ism_pkg::result_type head
);
   import ism_pkg::*;

   result_type             res_q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   push;
   logic                   pop;

   assign res_full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign head      = res_q_ff[rd_ptr_ff];
   assign push      = res_push && !res_full;
   assign pop       = rsp_pop && !rsp_empty;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            res_q_ff[wr_ptr_ff] <= res;
            wr_ptr_ff           <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/ising_metropolis_update.sv -----
// Metropolis spin-flip engine for a periodic square Ising lattice.
// Items enter through a queue-style port: drive the req_ fields and raise
// req_push while req_full is low. Kind 0 is a trial at a site with a random
// fraction, kind 1 writes one spin, kind 2 sets every spin up.
// Each item gives exactly one result, read from the rsp_ side while
// rsp_empty is low and taken with rsp_pop; results come out in item order.
// Each item passes through the engine states idle, center, eval and done;
// the engine finishes one item before it takes the next. The lattice memory
// does one read-modify-write of a site per item, reading the two neighbor
// rows together, then the center row, then evaluating and writing back.
// Two item slots sit in front of the engine and two result slots behind it.
// When the receiver stalls, the result slots fill, the engine holds its
// finished item, and req_full rises once the front slots are used.
// Reset sets all spins up, the energy to its all-up value, every ratio to
// one, and empties both queues, with no clearing pass. The user must write
// ratio registers via csr_ only while no item is in flight (not enforced).
module ising_metropolis_update (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [ism_pkg::KIND_W-1:0]          req_kind,
   input  logic [ism_pkg::COORD_W-1:0]         req_site_row,
   input  logic [ism_pkg::COORD_W-1:0]         req_site_col,
   input  logic [ism_pkg::FRAC_W-1:0]          req_rand_frac,
   input  logic                                req_spin_up,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_accepted,
   output logic signed [ism_pkg::DELTA_W-1:0]  rsp_delta_energy,
   output logic signed [ism_pkg::ENERGY_OUT_W-1:0] rsp_energy,
   output logic signed [ism_pkg::MAG_OUT_W-1:0] rsp_magnetization,
   output logic                                rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ism_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ism_pkg::RATIO_W-1:0]         csr_wdata
);
   import ism_pkg::*;

   ratio_set_type ratio_ff;
   ratio_set_type ratio_in;
   op_type        op;
   logic          op_valid;
   logic          op_pop;
   logic          res_full;
   logic          res_push;
   result_type    res;
   result_type    head;

   assign csr_ready = 1'b1;

   always_comb begin
      ratio_in = ratio_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RATIO_MINUS8: ratio_in.minus8 = csr_wdata;
            CSR_RATIO_MINUS4: ratio_in.minus4 = csr_wdata;
            CSR_RATIO_PLUS4:  ratio_in.plus4  = csr_wdata;
            CSR_RATIO_PLUS8:  ratio_in.plus8  = csr_wdata;
            default:          ratio_in        = ratio_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff.minus8 <= RATIO_ONE;
         ratio_ff.minus4 <= RATIO_ONE;
         ratio_ff.plus4  <= RATIO_ONE;
         ratio_ff.plus8  <= RATIO_ONE;
      end else begin
         ratio_ff <= ratio_in;
      end
   end

   ism_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_kind      (req_kind),
      .req_site_row  (req_site_row),
      .req_site_col  (req_site_col),
      .req_rand_frac (req_rand_frac),
      .req_spin_up   (req_spin_up),
      .op            (op),
      .op_valid      (op_valid),
      .op_pop        (op_pop)
   );

   ism_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .op_valid (op_valid),
      .op_pop   (op_pop),
      .ratios   (ratio_ff),
      .res_full (res_full),
      .res_push (res_push),
      .res      (res)
   );

   ism_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .res_push  (res_push),
      .res       (res),
      .res_full  (res_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .head      (head)
   );

   assign rsp_accepted      = head.accepted;
   assign rsp_delta_energy  = head.delta_energy;
   assign rsp_energy        = head.energy;
   assign rsp_magnetization = head.magnetization;
   assign rsp_status        = head.status;

endmodule

// ----- hdl/ism_checker.sv -----
`include "ising_metropolis_update_assert.svh"

module ism_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_full,
   input logic                                    rsp_empty,
   input logic                                    rsp_pop,
   input logic                                    rsp_accepted,
   input logic signed [ism_pkg::DELTA_W-1:0]      rsp_delta_energy,
   input logic signed [ism_pkg::ENERGY_OUT_W-1:0] rsp_energy,
   input logic signed [ism_pkg::MAG_OUT_W-1:0]    rsp_magnetization,
   input logic                                    rsp_status
);

   // A waiting item keeps its totals until it is taken.
   `ISM_ASSERT(a_rsp_hold,
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_energy) && $stable(rsp_magnetization)),
      "result changed while stalled")

   // A coordinate error never reports a spin change.
   `ISM_ASSERT(a_err_no_flip,
      (!rsp_empty && rsp_status) |-> (!rsp_accepted && rsp_delta_energy == '0),
      "error item reports a flip")

   // Without a flip the energy change is zero.
   `ISM_ASSERT(a_reject_zero,
      (!rsp_empty && !rsp_accepted) |-> (rsp_delta_energy == '0),
      "rejected item has energy change")

   // A single flip changes the energy by a multiple of four.
   `ISM_ASSERT(a_delta_step,
      !rsp_empty |-> (rsp_delta_energy[1:0] == 2'b00),
      "energy change not a multiple of four")

   // Reset empties both sides.
   `ISM_ASSERT_ALWAYS(a_reset_empty,
      reset |=> (rsp_empty && !req_full),
      "queues not empty after reset")

endmodule

bind ising_metropolis_update ism_checker u_ism_checker (.*);
